>>> rtl/sau_pkg.sv
// ============================================================================
// sau_pkg : shared types and constants for the stack arithmetic unit
// Opcodes, status codes, field widths and the control/status structs that
// pass between the sequencer and the iterative arithmetic unit.
// ============================================================================
`default_nettype none

package sau_pkg;

    // Field widths
    localparam int OP_W    = 3;
    localparam int DATA_W  = 32;
    localparam int ST_W    = 2;
    localparam int DEPTH_W = 7;
    localparam int LIMIT_W = 7;

    // Stream beat widths (fields packed from bit 0, padded to whole bytes)
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // Q16.16 fraction bits and iterative step counts
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = DATA_W + FRAC_W;
    localparam int MUL_STEPS = DATA_W;
    localparam int DIV_STEPS = QUO_W;
    localparam int CNT_W     = 6;

    // Operations
    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_POP  = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD  = 3'd2;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd3;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd4;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd5;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_STACK_ERR = 2'd1;
    localparam logic [ST_W-1:0] ST_DIV_ZERO  = 2'd2;

    // Saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // Stack limit after reset
    localparam logic [LIMIT_W-1:0] LIMIT_RST = 7'd64;

    // Sequencer to arithmetic unit
    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } t_arith_ctrl;

    // Arithmetic unit back to sequencer
    typedef struct packed {
        logic done;
        logic div_zero;
    } t_arith_stat;

endpackage

`default_nettype wire

>>> rtl/sau_arith.sv
// ============================================================================
// sau_arith : iterative Q16.16 arithmetic unit
// One 34-bit adder/subtractor serves add, sub, shift-add multiply,
// restoring divide and the final negation; all results saturate.
// ============================================================================
`default_nettype none

module sau_arith (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire  sau_pkg::t_arith_ctrl i_ctrl,
    input  wire  [sau_pkg::DATA_W-1:0] i_opa,
    input  wire  [sau_pkg::DATA_W-1:0] i_opb,
    output sau_pkg::t_arith_stat      o_stat,
    output logic [sau_pkg::DATA_W-1:0] o_result
);
    import sau_pkg::*;

    localparam logic [1:0] A_IDLE = 2'd0;
    localparam logic [1:0] A_ITER = 2'd1;
    localparam logic [1:0] A_FIN  = 2'd2;

    localparam int SUM_W = DATA_W + 2;

    logic [1:0]        r_state, n_state;
    logic [DATA_W-1:0] r_hi, n_hi;
    logic [QUO_W-1:0]  r_lo, n_lo;
    logic [DATA_W-1:0] r_opnd, n_opnd;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_neg, n_neg;
    logic              r_is_div, n_is_div;
    logic              r_done, n_done;
    logic              r_dz, n_dz;
    logic [DATA_W-1:0] r_res, n_res;

    logic [SUM_W-1:0]  w_x, w_y, w_sum;
    logic              w_sub;
    logic [QUO_W-1:0]  w_q;
    logic [DATA_W:0]   w_mstep;
    logic [DATA_W:0]   w_rem_sh;

    function automatic logic [DATA_W-1:0] f_mag(input logic [DATA_W-1:0] v);
        f_mag = v[DATA_W-1] ? (~v + 32'd1) : v;
    endfunction

    // Quotient or scaled product magnitude
    assign w_q      = r_is_div ? r_lo : {r_hi, r_lo[QUO_W-1:DATA_W]};
    assign w_rem_sh = {r_hi, r_lo[QUO_W-1]};

    // Operand selection for the shared adder
    always_comb begin
        w_x   = '0;
        w_y   = '0;
        w_sub = 1'b0;
        case (r_state)
            A_IDLE: begin
                w_x   = {{2{i_opa[DATA_W-1]}}, i_opa};
                w_y   = {{2{i_opb[DATA_W-1]}}, i_opb};
                w_sub = (i_ctrl.op == OP_SUB);
            end
            A_ITER: begin
                w_y = {2'b00, r_opnd};
                if (r_is_div) begin
                    w_x   = {1'b0, w_rem_sh};
                    w_sub = 1'b1;
                end else begin
                    w_x = {2'b00, r_hi};
                end
            end
            A_FIN: begin
                w_y   = {2'b00, w_q[DATA_W-1:0]};
                w_sub = 1'b1;
            end
            default: begin
                w_sub = 1'b0;
            end
        endcase
    end

    assign w_sum   = w_x + (w_sub ? ~w_y : w_y) + {{(SUM_W-1){1'b0}}, w_sub};
    assign w_mstep = r_lo[FRAC_W] ? w_sum[DATA_W:0] : {1'b0, r_hi};

    // Sequencer of the unit
    always_comb begin
        n_state  = r_state;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_opnd   = r_opnd;
        n_cnt    = r_cnt;
        n_neg    = r_neg;
        n_is_div = r_is_div;
        n_done   = 1'b0;
        n_dz     = r_dz;
        n_res    = r_res;
        case (r_state)
            A_IDLE: begin
                if (i_ctrl.start) begin
                    n_neg    = i_opa[DATA_W-1] ^ i_opb[DATA_W-1];
                    n_is_div = (i_ctrl.op == OP_DIV);
                    n_hi     = '0;
                    n_dz     = 1'b0;
                    if (i_ctrl.op == OP_ADD || i_ctrl.op == OP_SUB) begin
                        // saturate the exact sum in one pass
                        if (!w_sum[SUM_W-1] && w_sum[DATA_W:DATA_W-1] != 2'b00) begin
                            n_res = SAT_MAX;
                        end else if (w_sum[SUM_W-1] && w_sum[DATA_W:DATA_W-1] != 2'b11) begin
                            n_res = SAT_MIN;
                        end else begin
                            n_res = w_sum[DATA_W-1:0];
                        end
                        n_done = 1'b1;
                    end else if (i_ctrl.op == OP_DIV) begin
                        if (i_opb == '0) begin
                            n_dz   = 1'b1;
                            n_done = 1'b1;
                        end else begin
                            n_opnd  = f_mag(i_opb);
                            n_lo    = {f_mag(i_opa), {FRAC_W{1'b0}}};
                            n_cnt   = CNT_W'(DIV_STEPS - 1);
                            n_state = A_ITER;
                        end
                    end else begin
                        n_opnd  = f_mag(i_opa);
                        n_lo    = {f_mag(i_opb), {FRAC_W{1'b0}}};
                        n_cnt   = CNT_W'(MUL_STEPS - 1);
                        n_state = A_ITER;
                    end
                end
            end
            A_ITER: begin
                if (r_is_div) begin
                    // restoring step: keep the shifted remainder on a borrow
                    if (w_sum[SUM_W-1]) begin
                        n_hi = w_rem_sh[DATA_W-1:0];
                    end else begin
                        n_hi = w_sum[DATA_W-1:0];
                    end
                    n_lo = {r_lo[QUO_W-2:0], ~w_sum[SUM_W-1]};
                end else begin
                    // shift-add step, product shifts in from the top
                    n_hi = w_mstep[DATA_W:1];
                    n_lo = {w_mstep[0], r_lo[QUO_W-1:1]};
                end
                if (r_cnt == '0) begin
                    n_state = A_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            A_FIN: begin
                // apply sign and saturate the magnitude
                if (!r_neg) begin
                    n_res = (w_q[QUO_W-1:DATA_W-1] != '0) ? SAT_MAX : w_q[DATA_W-1:0];
                end else if (w_q[QUO_W-1:DATA_W] != '0 ||
                             (w_q[DATA_W-1] && w_q[DATA_W-2:0] != '0)) begin
                    n_res = SAT_MIN;
                end else begin
                    n_res = w_sum[DATA_W-1:0];
                end
                n_done  = 1'b1;
                n_state = A_IDLE;
            end
            default: begin
                n_state = A_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= A_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_opnd   <= n_opnd;
        r_cnt    <= n_cnt;
        r_neg    <= n_neg;
        r_is_div <= n_is_div;
        r_dz     <= n_dz;
        r_res    <= n_res;
    end

    assign o_stat.done     = r_done;
    assign o_stat.div_zero = r_dz;
    assign o_result        = r_res;

endmodule

`default_nettype wire

>>> rtl/stack_arithmetic_unit.sv
// ============================================================================
// stack_arithmetic_unit : operand stack with Q16.16 arithmetic
// Push, pop, add, sub, mul and div on a stack held in a single-port-read
// memory; one status beat returned for every instruction beat.
// ============================================================================
//
//  Channel   Dir  Handshake                 Payload (low bit first)
//  s_axis    in   i_s_axis_tvalid/o_tready  req_type[2:0], push_value[34:3]
//  m_axis    out  o_m_axis_tvalid/i_tready  status[1:0], result_value[33:2],
//                                           stack_depth[40:34]
//  cfg       in   i_cfg_we                  stack_limit[6:0]
//
//  Mul runs 32 shift-add steps and div 48 restoring steps, all on the
//  single shared adder in sau_arith; operands are read one at a time
//  through the one memory read port.
//  One instruction at a time: o_s_axis_tready is high only while idle.
//  A finished beat waits in the output register while the next one is taken.
//  Reset (synchronous, active low) empties the stack and sets the limit to 64.
//
`default_nettype none

module stack_arithmetic_unit #(
    parameter int STACK_DEPTH = 64
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // instruction beat: req_type, push_value
    input  wire                               i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  wire  [sau_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // result beat: status, result_value, stack_depth
    output logic                              o_m_axis_tvalid,
    input  wire                               i_m_axis_tready,
    output logic [sau_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // stack_limit register
    input  wire                               i_cfg_we,
    input  wire  [sau_pkg::LIMIT_W-1:0]       i_cfg_wdata
);
    import sau_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int XW = ((AW + 1) > DEPTH_W) ? (AW + 1) : DEPTH_W;
    localparam logic [XW-1:0] DEPTH_X = XW'(STACK_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD_A  = 3'd1;
    localparam logic [2:0] S_RD_B  = 3'd2;
    localparam logic [2:0] S_PREP  = 3'd3;
    localparam logic [2:0] S_START = 3'd4;
    localparam logic [2:0] S_WAIT  = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    logic [2:0]           r_state, n_state;
    logic [DEPTH_W-1:0]   r_depth, n_depth;
    logic [LIMIT_W-1:0]   r_limit;
    logic [OP_W-1:0]      r_op, n_op;
    logic [ST_W-1:0]      r_status, n_status;
    logic [DATA_W-1:0]    r_res, n_res;
    logic [DATA_W-1:0]    r_a, n_a;
    logic [DATA_W-1:0]    r_b, n_b;
    logic                 r_m_valid, n_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_data, n_m_data;

    logic [DATA_W-1:0]    mem [STACK_DEPTH];
    logic [DATA_W-1:0]    r_rd_data;

    logic [XW-1:0]        w_depth_x, w_cap_x, w_limit_x, w_raddr_x;
    logic                 w_full;
    logic                 w_we;
    logic [AW-1:0]        w_waddr, w_raddr;
    logic [DATA_W-1:0]    w_wdata;
    logic [OP_W-1:0]      w_req_type;
    logic [DATA_W-1:0]    w_push_value;
    logic                 w_accept;
    logic                 w_out_free;

    t_arith_ctrl          w_ctrl;
    t_arith_stat          w_stat;
    logic [DATA_W-1:0]    w_arith_res;

    // Unpack the instruction beat
    assign w_req_type   = i_s_axis_tdata[OP_W-1:0];
    assign w_push_value = i_s_axis_tdata[OP_W+DATA_W-1:OP_W];
    assign w_accept     = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free   = !r_m_valid || i_m_axis_tready;

    // Effective capacity is the smaller of the limit and the memory size
    assign w_depth_x = XW'(r_depth);
    assign w_limit_x = XW'(r_limit);
    assign w_cap_x   = (w_limit_x < DEPTH_X) ? w_limit_x : DEPTH_X;
    assign w_full    = (w_depth_x >= w_cap_x);

    // Read the top entry first, then the one below it
    assign w_raddr_x = (r_state == S_RD_B) ? (w_depth_x - XW'(2)) : (w_depth_x - XW'(1));
    assign w_raddr   = w_raddr_x[AW-1:0];
    assign w_waddr   = w_depth_x[AW-1:0];

    // Arithmetic unit
    assign w_ctrl.start = (r_state == S_START);
    assign w_ctrl.op    = r_op;

    sau_arith u_arith (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_ctrl),
        .i_opa    (r_a),
        .i_opb    (r_b),
        .o_stat   (w_stat),
        .o_result (w_arith_res)
    );

    // Sequencer
    always_comb begin
        n_state   = r_state;
        n_depth   = r_depth;
        n_op      = r_op;
        n_status  = r_status;
        n_res     = r_res;
        n_a       = r_a;
        n_b       = r_b;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        w_we      = 1'b0;
        w_wdata   = w_push_value;

        // drop the output beat once taken
        if (r_m_valid && i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = w_req_type;
                    n_res    = '0;
                    n_status = ST_OK;
                    n_state  = S_OUT;
                    case (w_req_type)
                        OP_PUSH: begin
                            if (w_full) begin
                                n_status = ST_STACK_ERR;
                            end else begin
                                w_we    = 1'b1;
                                n_depth = r_depth + 1'b1;
                            end
                        end
                        OP_POP: begin
                            if (r_depth == '0) begin
                                n_status = ST_STACK_ERR;
                            end else begin
                                n_depth = r_depth - 1'b1;
                            end
                        end
                        OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                            if (r_depth == '0) begin
                                n_status = ST_STACK_ERR;
                            end else if (r_depth == DEPTH_W'(1)) begin
                                // lone operand is still consumed
                                n_status = ST_STACK_ERR;
                                n_depth  = '0;
                            end else begin
                                n_state = S_RD_A;
                            end
                        end
                        default: begin
                            n_status = ST_STACK_ERR;
                        end
                    endcase
                end
            end
            S_RD_A: begin
                n_state = S_RD_B;
            end
            S_RD_B: begin
                n_a     = r_rd_data;
                n_state = S_PREP;
            end
            S_PREP: begin
                n_b     = r_rd_data;
                n_depth = r_depth - DEPTH_W'(2);
                n_state = S_START;
            end
            S_START: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_stat.done) begin
                    if (w_stat.div_zero) begin
                        n_status = ST_DIV_ZERO;
                        n_state  = S_OUT;
                    end else begin
                        n_res   = w_arith_res;
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (w_full) begin
                    n_status = ST_STACK_ERR;
                    n_res    = '0;
                end else begin
                    w_we    = 1'b1;
                    w_wdata = r_res;
                    n_depth = r_depth + 1'b1;
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                // hold until the output register is free
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {{(OUT_TDATA_W-DEPTH_W-DATA_W-ST_W){1'b0}},
                                 r_depth, r_res, r_status};
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_depth   <= '0;
            r_limit   <= LIMIT_RST;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_depth   <= n_depth;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_res    <= n_res;
        r_a      <= n_a;
        r_b      <= n_b;
        r_m_data <= n_m_data;
    end

    // Stack memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rd_data <= mem[w_raddr];
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;

endmodule

`default_nettype wire

>>> rtl/sau_checker.sv
// ============================================================================
// sau_checker : port-level checks for the stack arithmetic unit
// Watches the stream ports over time; bound to the top.
// ============================================================================
`default_nettype none

module sau_checker (
    input wire                             i_clk,
    input wire                             i_rst_n,
    input wire                             i_s_axis_tvalid,
    input wire                             o_s_axis_tready,
    input wire                             o_m_axis_tvalid,
    input wire                             i_m_axis_tready,
    input wire [sau_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);
    import sau_pkg::*;

    // Reset empties the output register
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output beat valid after reset");

    // Hold a stalled output beat
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled output beat changed");

    // One instruction at a time: ready drops after each accepted beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second instruction taken while busy");

    // A failed instruction returns a zero value
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[ST_W-1:0] != ST_OK
        |-> o_m_axis_tdata[ST_W+DATA_W-1:ST_W] == '0)
        else $error("non-zero value on failed instruction");

endmodule

bind stack_arithmetic_unit sau_checker u_sau_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

>>> tb/sv/sau_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// sau_result_checker : prediction and comparison for the stack arithmetic unit
// Watches the instruction, result and limit channels, keeps its own copy of
// the operand stack, and compares every result beat with the oldest
// prediction field by field.
// ============================================================================

module sau_result_checker #(
    parameter int STACK_SLOTS = 64
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_axis_tvalid,
    input  wire                              i_s_axis_tready,
    // req_type, push_value
    input  wire  [sau_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    input  wire                              i_m_axis_tvalid,
    input  wire                              i_m_axis_tready,
    // status, result_value, stack_depth
    input  wire  [sau_pkg::OUT_TDATA_W-1:0]  i_m_axis_tdata,
    input  wire                              i_cfg_we,
    input  wire  [sau_pkg::LIMIT_W-1:0]      i_cfg_wdata,
    output int unsigned                      o_fail_count,
    output int unsigned                      o_pending
);
    import sau_pkg::*;

    localparam int     MAX_REPORTS = 10;
    localparam longint Q_ONE       = longint'(1) << FRAC_W;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [DATA_W-1:0]  value;
        logic [DEPTH_W-1:0] depth;
    } t_result;

    // Shadow copy of the operand stack and its limit
    logic [DATA_W-1:0] slot_mem [STACK_SLOTS];
    int unsigned       depth_now;
    int unsigned       limit_now;
    t_result           expected_q [$];
    int unsigned       fail_total;

    // Clamp an exact result to the signed 32-bit range
    function automatic logic [DATA_W-1:0] clamp32(input longint v);
        if (v > longint'($signed(SAT_MAX)))
            return SAT_MAX;
        if (v < longint'($signed(SAT_MIN)))
            return SAT_MIN;
        return v[DATA_W-1:0];
    endfunction

    // Apply one instruction to the shadow stack and return its result beat
    function automatic t_result predict_instr(input logic [OP_W-1:0] op,
                                              input logic [DATA_W-1:0] pv);
        t_result     r;
        int unsigned cap;
        longint      a;
        longint      b;
        longint      acc;
        logic        ok;
        r.status = ST_OK;
        r.value  = '0;
        acc      = 0;
        cap      = (limit_now < STACK_SLOTS) ? limit_now : STACK_SLOTS;
        case (op)
            OP_PUSH: begin
                if (depth_now < cap) begin
                    slot_mem[depth_now] = pv;
                    depth_now++;
                end else begin
                    r.status = ST_STACK_ERR;
                end
            end
            OP_POP: begin
                if (depth_now > 0)
                    depth_now--;
                else
                    r.status = ST_STACK_ERR;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                if (depth_now < 2) begin
                    // empty: untouched; one entry: that entry is dropped
                    depth_now = 0;
                    r.status  = ST_STACK_ERR;
                end else begin
                    a  = longint'($signed(slot_mem[depth_now-1]));
                    b  = longint'($signed(slot_mem[depth_now-2]));
                    depth_now -= 2;
                    ok = 1'b1;
                    case (op)
                        OP_ADD: acc = a + b;
                        OP_SUB: acc = a - b;
                        OP_MUL: acc = (a * b) / Q_ONE;
                        default: begin
                            if (b == 0) begin
                                ok       = 1'b0;
                                r.status = ST_DIV_ZERO;
                            end else begin
                                acc = (a * Q_ONE) / b;
                            end
                        end
                    endcase
                    // push the result back unless the limit forbids it
                    if (ok) begin
                        if (depth_now < cap) begin
                            slot_mem[depth_now] = clamp32(acc);
                            r.value             = clamp32(acc);
                            depth_now++;
                        end else begin
                            r.status = ST_STACK_ERR;
                        end
                    end
                end
            end
            default: r.status = ST_STACK_ERR;
        endcase
        r.depth = depth_now[DEPTH_W-1:0];
        return r;
    endfunction

    task automatic log_miss(input string why, input t_result want, input t_result got);
        fail_total++;
        if (fail_total <= MAX_REPORTS)
            $display({"[%0t] %s: expected status %0d value %h depth %0d,",
                      " got status %0d value %h depth %0d"},
                     $time, why, want.status, want.value, want.depth,
                     got.status, got.value, got.depth);
    endtask

    // Predict on instruction beats, compare on result beats
    always @(posedge i_clk) begin : watch
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            depth_now = 0;
            limit_now = LIMIT_RST;
            expected_q.delete();
        end else begin
            if (i_cfg_we)
                limit_now = i_cfg_wdata;
            if (i_s_axis_tvalid && i_s_axis_tready)
                expected_q.push_back(predict_instr(i_s_axis_tdata[OP_W-1:0],
                                                   i_s_axis_tdata[OP_W +: DATA_W]));
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.status = i_m_axis_tdata[ST_W-1:0];
                got.value  = i_m_axis_tdata[ST_W +: DATA_W];
                got.depth  = i_m_axis_tdata[ST_W+DATA_W +: DEPTH_W];
                if (expected_q.size() == 0) begin
                    log_miss("result beat with nothing expected", '0, got);
                end else begin
                    want = expected_q.pop_front();
                    if (want !== got)
                        log_miss("result mismatch", want, got);
                end
            end
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_total;
    end

endmodule

>>> tb/sv/tb_stack_arithmetic_unit.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_stack_arithmetic_unit : stimulus and verdict for the stack arithmetic unit
// Drives a directed run over the stack and arithmetic corner cases, then
// random instruction phases under a range of stack limits, with random
// gaps on both streams. A separate checker predicts and compares results.
// ============================================================================

module tb_stack_arithmetic_unit;
    import sau_pkg::*;

    localparam int CLK_PERIOD      = 12;
    localparam int RESET_CYCLES    = 9;
    localparam int SETTLE_CYCLES   = 8;
    localparam int TAIL_CYCLES     = 120;
    localparam int TIMEOUT_NS      = 20_000_000;
    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 180;

    // Opcodes the block must reject
    localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

    // Limit and push share (percent) of each random phase
    int phase_limit [PHASES] = '{64, 1, 2, 13, 0, 33, 16, 64, 7, 64};
    int phase_push  [PHASES] = '{50, 50, 55, 50, 50, 50, 55, 85, 50, 30};

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   instr_valid;
    logic                   instr_ready;
    logic [IN_TDATA_W-1:0]  instr_data;
    logic                   res_valid;
    logic                   res_ready;
    logic [OUT_TDATA_W-1:0] res_data;
    logic                   lim_we;
    logic [LIMIT_W-1:0]     lim_data;
    int unsigned            fail_count;
    int unsigned            pending;
    int                     send_quiet;
    int                     recv_quiet;

    always #(CLK_PERIOD / 2) clk = ~clk;

    stack_arithmetic_unit dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (instr_valid),
        .o_s_axis_tready (instr_ready),
        .i_s_axis_tdata  (instr_data),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .i_cfg_we        (lim_we),
        .i_cfg_wdata     (lim_data)
    );

    sau_result_checker checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (instr_valid),
        .i_s_axis_tready (instr_ready),
        .i_s_axis_tdata  (instr_data),
        .i_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .i_m_axis_tdata  (res_data),
        .i_cfg_we        (lim_we),
        .i_cfg_wdata     (lim_data),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Gap before the next beat, with occasional stretches of back-to-back beats
    function automatic int draw_gap(inout int quiet);
        if (quiet > 0) begin
            quiet--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Mix of zeros, extremes, small Q16.16 numbers and raw random words
    function automatic logic [DATA_W-1:0] draw_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = SAT_MAX;
                    1: v = SAT_MIN;
                    2: v = 32'h0000_0001;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            2, 3, 4: v = $urandom();
            default: begin
                v = {8'h00, 8'($urandom_range(0, 255)), 16'($urandom())};
                if ($urandom_range(0, 1))
                    v = -v;
            end
        endcase
        return v;
    endfunction

    function automatic logic [OP_W-1:0] draw_op(input int push_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return OP_PUSH;
        r = $urandom_range(0, 99);
        if (r < 5)
            return $urandom_range(0, 1) ? OP_BAD_HI : OP_BAD_LO;
        if (r < 25)
            return OP_POP;
        case ($urandom_range(0, 3))
            0: return OP_ADD;
            1: return OP_SUB;
            2: return OP_MUL;
            default: return OP_DIV;
        endcase
    endfunction

    // Send one instruction beat after a random gap and hold until accepted
    task automatic put_instr(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
        int gap;
        gap = draw_gap(send_quiet);
        @(negedge clk);
        if (gap > 0) begin
            instr_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        instr_valid <= 1'b1;
        instr_data  <= {{(IN_TDATA_W-OP_W-DATA_W){1'b0}}, val, op};
        do @(posedge clk); while (!instr_ready);
    endtask

    // Hold the instruction stream until every result is back and the unit idles
    task automatic drain();
        @(negedge clk);
        instr_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_stack_limit(input logic [LIMIT_W-1:0] lim);
        drain();
        @(negedge clk);
        lim_we   <= 1'b1;
        lim_data <= lim;
        @(negedge clk);
        lim_we   <= 1'b0;
    endtask

    // Result side: random stalls on every beat
    initial begin
        int gap;
        res_ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            gap = draw_gap(recv_quiet);
            @(negedge clk);
            if (gap > 0) begin
                res_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ready <= 1'b1;
            do @(posedge clk); while (!res_valid);
        end
    end

    // Stimulus and verdict
    initial begin
        rst_n       = 1'b0;
        instr_valid = 1'b0;
        instr_data  = '0;
        lim_we      = 1'b0;
        lim_data    = '0;
        send_quiet  = 0;
        recv_quiet  = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Empty stack and rejected opcodes
        put_instr(OP_POP, '0);
        put_instr(OP_ADD, '0);
        put_instr(OP_BAD_LO, 32'hFFFF_FFFF);
        put_instr(OP_BAD_HI, '0);
        // Saturating add, then arithmetic on a single entry
        put_instr(OP_PUSH, SAT_MAX);
        put_instr(OP_PUSH, SAT_MAX);
        put_instr(OP_ADD, '0);
        put_instr(OP_SUB, '0);
        // Saturating multiply of the most negative values
        put_instr(OP_PUSH, SAT_MIN);
        put_instr(OP_PUSH, SAT_MIN);
        put_instr(OP_MUL, '0);
        // Division by zero drops both operands
        put_instr(OP_PUSH, '0);
        put_instr(OP_PUSH, 32'h0003_0000);
        put_instr(OP_DIV, '0);
        // Saturating divide by the smallest step, then saturating subtract
        put_instr(OP_PUSH, 32'h0000_0001);
        put_instr(OP_PUSH, SAT_MIN);
        put_instr(OP_DIV, '0);
        put_instr(OP_SUB, '0);
        // Negative quotient truncates toward zero
        put_instr(OP_PUSH, 32'h0003_0000);
        put_instr(OP_PUSH, 32'hFFF9_0000);
        put_instr(OP_DIV, '0);
        put_instr(OP_MUL, '0);
        put_instr(OP_POP, '0);
        // Single-entry limit: push onto a full stack
        set_stack_limit(7'd1);
        put_instr(OP_PUSH, draw_value());
        put_instr(OP_PUSH, draw_value());
        put_instr(OP_ADD, '0);

        // Random phases; each limit change lands on whatever depth is left
        for (int p = 0; p < PHASES; p++) begin
            set_stack_limit(phase_limit[p][LIMIT_W-1:0]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                put_instr(draw_op(phase_push[p]), draw_value());
        end

        drain();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("stack_arithmetic_unit verification clean");
        else
            $display("stack_arithmetic_unit verification failed");
        $finish;
    end

    // Hard stop if the run hangs
    initial begin
        #(TIMEOUT_NS);
        $display("stack_arithmetic_unit verification failed");
        $finish;
    end

endmodule
